### sv/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the disk seek scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned CylW       = 16;
  localparam int unsigned FcfsOutW   = 21;
  localparam int unsigned FcfsSumW   = 22;
  localparam int unsigned TravelW    = 17;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned RequestsDef = 32;
  localparam logic [CylW-1:0] MaxCylReset = 16'd299;

  localparam logic [CfgIdxW-1:0] CfgHead  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDir   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxCyl = 2'd2;

  localparam logic KindEntry  = 1'b0;
  localparam logic KindTotals = 1'b1;

  typedef enum logic [1:0] {
    BkIdle,
    BkPrep,
    BkFirst,
    BkSecond
  } bk_state_e;

  // front -> back batch hand-off
  typedef struct packed {
    logic [FcfsOutW-1:0] fcfs;
  } batch_t;

endpackage

### sv/disk_seek_scheduler.sv
// ----------------------------------------------------------------------------
// disk_seek_scheduler
// FCFS / SCAN / LOOK disk head scheduling over a batch of requests.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         req_valid_i/req_ready_o  request_cylinder_i
// result    out        out_valid_o/out_ready_i  item_kind_o .. last_item_o
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// Front takes one request per cycle into the sorting chain; it stalls only
// while a full batch waits for the back. The back registers a batch snapshot,
// finds the split and the totals, then walks both sweep phases, emitting each
// served request and skipping those at the head, then the totals. The front
// loads the next batch meanwhile. Reset clears control only; no clearing pass.
module disk_seek_scheduler #(
  parameter int unsigned Requests = dss_pkg::RequestsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dss_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [dss_pkg::CylW-1:0]      request_cylinder_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          item_kind_o,
  output logic [dss_pkg::CylW-1:0]      served_cylinder_o,
  output logic [dss_pkg::FcfsOutW-1:0]  fcfs_travel_o,
  output logic [dss_pkg::TravelW-1:0]   scan_travel_o,
  output logic [dss_pkg::TravelW-1:0]   look_travel_o,
  output logic                          last_item_o
);

  logic [dss_pkg::CylW-1:0] head_q, maxc_q;
  logic                     dir_q;
  logic                     bvalid, btake;
  dss_pkg::batch_t          batch;
  logic [dss_pkg::CylW-1:0] sorted [Requests];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      dir_q  <= 1'b0;
      maxc_q <= dss_pkg::MaxCylReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dss_pkg::CfgHead:   head_q <= cfg_data_i;
        dss_pkg::CfgDir:    dir_q  <= cfg_data_i[0];
        dss_pkg::CfgMaxCyl: maxc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dss_front #(.Requests(Requests)) u_front (
    .clk_i, .rst_ni,
    .head_i(head_q),
    .req_valid_i, .req_ready_o,
    .req_cyl_i(request_cylinder_i),
    .batch_valid_o(bvalid),
    .batch_take_i(btake),
    .batch_o(batch),
    .sorted_o(sorted)
  );

  dss_back #(.Requests(Requests)) u_back (
    .clk_i, .rst_ni,
    .head_i(head_q), .dir_i(dir_q), .max_cyl_i(maxc_q),
    .batch_valid_i(bvalid), .batch_take_o(btake),
    .batch_i(batch), .sorted_i(sorted),
    .out_valid_o, .out_ready_i,
    .kind_o(item_kind_o), .cyl_o(served_cylinder_o),
    .fcfs_o(fcfs_travel_o), .scan_o(scan_travel_o),
    .look_o(look_travel_o), .last_o(last_item_o)
  );

  a_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    btake |-> bvalid) else $error("batch taken while not full");
  a_no_req_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid && !btake |=> !req_ready_o) else $error("ready while batch pending");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_item_o == item_kind_o)) else $error("last/kind mismatch");

endmodule

### sv/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Accepts requests, sums FCFS travel and keeps an insertion-sorted chain.
// ----------------------------------------------------------------------------
module dss_front #(
  parameter int unsigned Requests = dss_pkg::RequestsDef,
  localparam int unsigned CntW = $clog2(Requests + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dss_pkg::CylW-1:0]    head_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [dss_pkg::CylW-1:0]    req_cyl_i,
  output logic                        batch_valid_o,
  input  logic                        batch_take_i,
  output dss_pkg::batch_t             batch_o,
  output logic [dss_pkg::CylW-1:0]    sorted_o [Requests]
);

  logic [dss_pkg::CylW-1:0]     srt_q [Requests];
  logic [dss_pkg::CylW-1:0]     srt_d [Requests];
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [dss_pkg::CylW-1:0]     prev_q, prev_d;
  logic [dss_pkg::FcfsSumW-1:0] sum_q, sum_d;
  logic                         full_q, full_d;
  logic [dss_pkg::CylW-1:0]     prev_eff, diff;
  logic                         take;

  assign req_ready_o   = !full_q;
  assign take          = req_valid_i && req_ready_o;
  assign batch_valid_o = full_q;
  assign sorted_o      = srt_q;
  assign batch_o.fcfs  = (sum_q > dss_pkg::FcfsSumW'((1 << dss_pkg::FcfsOutW) - 1))
                         ? {dss_pkg::FcfsOutW{1'b1}} : sum_q[dss_pkg::FcfsOutW-1:0];

  assign prev_eff = (cnt_q == '0) ? head_i : prev_q;
  assign diff     = (prev_eff >= req_cyl_i) ? prev_eff - req_cyl_i : req_cyl_i - prev_eff;

  always_comb begin
    srt_d  = srt_q;
    cnt_d  = cnt_q;
    prev_d = prev_q;
    sum_d  = sum_q;
    full_d = full_q;
    if (take) begin
      prev_d = req_cyl_i;
      sum_d  = sum_q + dss_pkg::FcfsSumW'(diff);
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(Requests - 1)) full_d = 1'b1;
      for (int i = 0; i < Requests; i++) begin
        if (CntW'(i) < cnt_q) begin
          if (srt_q[i] > req_cyl_i) begin
            if (i == 0 || srt_q[(i == 0) ? 0 : i-1] <= req_cyl_i) srt_d[i] = req_cyl_i;
            else srt_d[i] = srt_q[(i == 0) ? 0 : i-1];
          end
        end else if (CntW'(i) == cnt_q) begin
          if (i != 0 && srt_q[(i == 0) ? 0 : i-1] > req_cyl_i)
            srt_d[i] = srt_q[(i == 0) ? 0 : i-1];
          else srt_d[i] = req_cyl_i;
        end
      end
    end
    if (full_q && batch_take_i) begin
      full_d = 1'b0;
      cnt_d  = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      full_q <= 1'b0;
      prev_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      full_q <= full_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srt_q <= srt_d;
  end

endmodule

### sv/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Holds a batch snapshot, walks the SCAN/LOOK order and emits the totals.
// ----------------------------------------------------------------------------
module dss_back #(
  parameter int unsigned Requests = dss_pkg::RequestsDef,
  localparam int unsigned IdxW = $clog2(Requests + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dss_pkg::CylW-1:0]    head_i,
  input  logic                        dir_i,
  input  logic [dss_pkg::CylW-1:0]    max_cyl_i,
  input  logic                        batch_valid_i,
  output logic                        batch_take_o,
  input  dss_pkg::batch_t             batch_i,
  input  logic [dss_pkg::CylW-1:0]    sorted_i [Requests],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [dss_pkg::CylW-1:0]    cyl_o,
  output logic [dss_pkg::FcfsOutW-1:0] fcfs_o,
  output logic [dss_pkg::TravelW-1:0] scan_o,
  output logic [dss_pkg::TravelW-1:0] look_o,
  output logic                        last_o
);

  localparam int unsigned AW = $clog2(Requests);

  dss_pkg::bk_state_e st_q, st_d;
  logic [dss_pkg::CylW-1:0]     buf_q [Requests];
  logic [dss_pkg::CylW-1:0]     h_q;
  logic                         dir_q;
  logic [dss_pkg::CylW-1:0]     m_q;
  logic [dss_pkg::FcfsOutW-1:0] fcfs_q;
  logic [IdxW-1:0]              split_q, split_d, idx_q, idx_d;
  logic                         ov_q, ov_d;
  logic                         kind_q, kind_d;
  logic [dss_pkg::CylW-1:0]     cyl_q, cyl_d;
  logic [dss_pkg::TravelW-1:0]  scan_q, scan_d, look_q, look_d;
  logic                         load, out_free, at_end, up_walk;
  logic [dss_pkg::CylW-1:0]     lo, hi, cur;
  logic [dss_pkg::TravelW-1:0]  d_hlo, d_hhi, d_mh, d_mlo, span;

  function automatic logic [dss_pkg::TravelW-1:0] adiff(
    input logic [dss_pkg::CylW-1:0] a, input logic [dss_pkg::CylW-1:0] b);
    adiff = (a >= b) ? dss_pkg::TravelW'(a - b) : dss_pkg::TravelW'(b - a);
  endfunction

  assign load     = batch_valid_i && (st_q == dss_pkg::BkIdle) && !ov_q;
  assign batch_take_o = load;
  assign out_free = !ov_q || out_ready_i;
  assign lo = buf_q[0];
  assign hi = buf_q[Requests-1];

  assign d_hlo = adiff(h_q, lo);
  assign d_hhi = adiff(h_q, hi);
  assign d_mh  = adiff(m_q, h_q);
  assign d_mlo = adiff(m_q, lo);
  assign span  = dss_pkg::TravelW'(hi - lo);

  // walk direction for current phase: first phase goes with sweep
  assign up_walk = (st_q == dss_pkg::BkFirst) ? dir_q : !dir_q;
  assign cur     = buf_q[idx_q[AW-1:0]];
  assign at_end  = up_walk ? (idx_q == IdxW'(Requests)) : (idx_q == '0);

  always_comb begin
    st_d    = st_q;
    split_d = split_q;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_ready_i;
    kind_d  = kind_q;
    cyl_d   = cyl_q;
    scan_d  = scan_q;
    look_d  = look_q;
    case (st_q)
      dss_pkg::BkIdle: begin
        if (load) begin
          st_d    = dss_pkg::BkPrep;
          split_d = IdxW'(Requests);
          idx_d   = '0;
        end
      end
      dss_pkg::BkPrep: begin
        // one element per cycle split search
        if (idx_q == IdxW'(Requests)) begin
          st_d  = dss_pkg::BkFirst;
          idx_d = dir_q ? split_q : split_q;
          if (!dir_q) begin
            scan_d = (h_q >= hi) ? dss_pkg::TravelW'(h_q)
                                 : dss_pkg::TravelW'(h_q) + dss_pkg::TravelW'(hi);
            look_d = (h_q >= hi) ? d_hlo : d_hlo + span;
          end else begin
            scan_d = (h_q <= lo) ? d_mh : d_mh + d_mlo;
            look_d = (h_q <= lo) ? dss_pkg::TravelW'(hi - h_q) : d_hhi + span;
          end
        end else begin
          if (split_q == IdxW'(Requests) && cur > h_q) split_d = idx_q;
          idx_d = idx_q + 1'b1;
        end
      end
      dss_pkg::BkFirst, dss_pkg::BkSecond: begin
        if (at_end) begin
          if (st_q == dss_pkg::BkFirst) begin
            st_d  = dss_pkg::BkSecond;
            idx_d = split_q;
          end else if (out_free) begin
            st_d   = dss_pkg::BkIdle;
            ov_d   = 1'b1;
            kind_d = dss_pkg::KindTotals;
            cyl_d  = '0;
          end
        end else if (up_walk) begin
          if (cur == h_q) idx_d = idx_q + 1'b1;
          else if (out_free) begin
            idx_d  = idx_q + 1'b1;
            ov_d   = 1'b1;
            kind_d = dss_pkg::KindEntry;
            cyl_d  = cur;
          end
        end else begin
          if (buf_q[idx_q[AW-1:0] - 1'b1] == h_q) idx_d = idx_q - 1'b1;
          else if (out_free) begin
            idx_d  = idx_q - 1'b1;
            ov_d   = 1'b1;
            kind_d = dss_pkg::KindEntry;
            cyl_d  = buf_q[idx_q[AW-1:0] - 1'b1];
          end
        end
      end
      default: st_d = dss_pkg::BkIdle;
    endcase
  end

  always_comb begin
    out_valid_o = ov_q;
    kind_o      = kind_q;
    cyl_o       = (kind_q == dss_pkg::KindEntry) ? cyl_q : '0;
    fcfs_o      = (kind_q == dss_pkg::KindTotals) ? fcfs_q : '0;
    scan_o      = (kind_q == dss_pkg::KindTotals) ? scan_q : '0;
    look_o      = (kind_q == dss_pkg::KindTotals) ? look_q : '0;
    last_o      = (kind_q == dss_pkg::KindTotals);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= dss_pkg::BkIdle;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      split_q <= '0;
      kind_q  <= dss_pkg::KindEntry;
    end else begin
      st_q    <= st_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      split_q <= split_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q  <= cyl_d;
    scan_q <= scan_d;
    look_q <= look_d;
    if (load) begin
      buf_q  <= sorted_i;
      h_q    <= head_i;
      dir_q  <= dir_i;
      m_q    <= max_cyl_i;
      fcfs_q <= batch_i.fcfs;
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for disk_seek_scheduler. Drives batches of cylinder requests
// under several head, direction and max-cylinder settings. Each batch is
// predicted in the bench: the FCFS sum, the ascending request list, the
// SCAN/LOOK service order and the travel totals. Every result is checked in
// order against that prediction. Both sides idle at random, and one phase
// stalls the result side long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NReq = dss_pkg::RequestsDef;

  typedef struct packed {
    logic                         kind;
    logic [dss_pkg::CylW-1:0]     cyl;
    logic [dss_pkg::FcfsOutW-1:0] fcfs;
    logic [dss_pkg::TravelW-1:0]  scan;
    logic [dss_pkg::TravelW-1:0]  look;
    logic                         last;
  } sched_out_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [dss_pkg::CfgIdxW-1:0]  cfg_idx_i = dss_pkg::CfgHead;
  logic [dss_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         req_valid_i = 1'b0;
  logic                         req_ready_o;
  logic [dss_pkg::CylW-1:0]     request_cylinder_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         item_kind_o;
  logic [dss_pkg::CylW-1:0]     served_cylinder_o;
  logic [dss_pkg::FcfsOutW-1:0] fcfs_travel_o;
  logic [dss_pkg::TravelW-1:0]  scan_travel_o;
  logic [dss_pkg::TravelW-1:0]  look_travel_o;
  logic                         last_item_o;

  disk_seek_scheduler dut (.*);

  always #4 clk_i = ~clk_i;

  // bench copy of configuration and batch state
  logic [dss_pkg::CylW-1:0]     head_q = '0;
  logic                         dir_q = 1'b0;
  logic [dss_pkg::CylW-1:0]     maxcyl_q = dss_pkg::MaxCylReset;
  logic [dss_pkg::CylW-1:0]     sorted_q[$];
  logic [dss_pkg::CylW-1:0]     prev_pos;
  logic [dss_pkg::FcfsSumW-1:0] fcfs_acc = '0;

  sched_out_t service_q[$];
  bit         idle_en = 1'b1;
  int         hold_cycles = 0;
  int         n_errors = 0;
  int         n_sent = 0;
  int         n_results = 0;
  int         n_batches = 0;

  function automatic logic [dss_pkg::TravelW:0] adist(logic [dss_pkg::TravelW:0] a,
                                                      logic [dss_pkg::TravelW:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic sched_out_t entry(logic [dss_pkg::CylW-1:0] c);
    sched_out_t r;
    r = '0;
    r.kind = dss_pkg::KindEntry;
    r.cyl  = c;
    return r;
  endfunction

  // accepted request: FCFS travel, sorted insert, full batch emits order
  task automatic predict_request(logic [dss_pkg::CylW-1:0] c);
    int pos;
    int split;
    logic [dss_pkg::TravelW:0] h, lo, hi, m, scan, look;
    sched_out_t tot;
    if (sorted_q.size() == 0) prev_pos = head_q;
    fcfs_acc = fcfs_acc + adist(prev_pos, c);
    prev_pos = c;
    pos = sorted_q.size();
    while (pos > 0 && sorted_q[pos-1] > c) pos--;
    sorted_q.insert(pos, c);
    if (sorted_q.size() < NReq) return;
    h = head_q; lo = sorted_q[0]; hi = sorted_q[NReq-1]; m = maxcyl_q;
    if (!dir_q) begin
      scan = (h >= hi) ? h : h + hi;
      look = (h >= hi) ? adist(h, lo) : adist(h, lo) + (hi - lo);
    end else begin
      scan = (h <= lo) ? adist(m, h) : adist(h, m) + adist(m, lo);
      look = (h <= lo) ? hi - h : adist(h, hi) + (hi - lo);
    end
    split = NReq;
    for (int i = 0; i < NReq; i++) begin
      if (sorted_q[i] > head_q) begin
        split = i;
        break;
      end
    end
    if (!dir_q) begin
      for (int i = split - 1; i >= 0; i--)
        if (sorted_q[i] != head_q) service_q.push_back(entry(sorted_q[i]));
      for (int i = split; i < NReq; i++)
        if (sorted_q[i] != head_q) service_q.push_back(entry(sorted_q[i]));
    end else begin
      for (int i = split; i < NReq; i++)
        if (sorted_q[i] != head_q) service_q.push_back(entry(sorted_q[i]));
      for (int i = split - 1; i >= 0; i--)
        if (sorted_q[i] != head_q) service_q.push_back(entry(sorted_q[i]));
    end
    tot = '0;
    tot.kind = dss_pkg::KindTotals;
    tot.fcfs = (fcfs_acc > 22'd2097151) ? 21'h1FFFFF : fcfs_acc[dss_pkg::FcfsOutW-1:0];
    tot.scan = scan[dss_pkg::TravelW-1:0];
    tot.look = look[dss_pkg::TravelW-1:0];
    tot.last = 1'b1;
    service_q.push_back(tot);
    sorted_q.delete();
    fcfs_acc = '0;
    n_batches++;
  endtask

  task automatic send_request(logic [dss_pkg::CylW-1:0] c);
    int gap;
    gap = idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    request_cylinder_i = c;
    req_valid_i = 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    predict_request(c);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [dss_pkg::CfgIdxW-1:0] idx,
                           logic [dss_pkg::CfgDataW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      dss_pkg::CfgHead:   head_q = val;
      dss_pkg::CfgDir:    dir_q = val[0];
      dss_pkg::CfgMaxCyl: maxcyl_q = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [dss_pkg::CylW-1:0] h, logic d,
                            logic [dss_pkg::CylW-1:0] m);
    write_cfg(dss_pkg::CfgHead, h);
    write_cfg(dss_pkg::CfgDir, {15'd0, d});
    write_cfg(dss_pkg::CfgMaxCyl, m);
  endtask

  task automatic drain();
    req_valid_i = 1'b0;
    while (service_q.size() != 0) @(negedge clk_i);
    repeat (NReq + 20) @(negedge clk_i);
  endtask

  // mode 0 uniform, 1 clustered near head, 2 many hits on the head
  task automatic random_batch(int mode);
    logic [dss_pkg::CylW-1:0] c;
    for (int i = 0; i < NReq; i++) begin
      case (mode)
        1: c = head_q + dss_pkg::CylW'($urandom_range(0, 64)) - 16'd32;
        2: c = ($urandom_range(0, 2) == 0) ? head_q : dss_pkg::CylW'($urandom);
        default: c = dss_pkg::CylW'($urandom);
      endcase
      send_request(c);
    end
  endtask

  // result side: random stall, long hold-off on request, then check
  initial begin
    int gap;
    sched_out_t exp_r;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      gap = idle_en ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_results++;
      if (service_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result kind=%0d cyl=%0d",
                                     item_kind_o, served_cylinder_o);
      end else begin
        exp_r = service_q.pop_front();
        if (item_kind_o !== exp_r.kind || served_cylinder_o !== exp_r.cyl ||
            fcfs_travel_o !== exp_r.fcfs || scan_travel_o !== exp_r.scan ||
            look_travel_o !== exp_r.look || last_item_o !== exp_r.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"ERROR: exp kind=%0d cyl=%0d fcfs=%0d scan=%0d look=%0d last=%0d",
                      " | got kind=%0d cyl=%0d fcfs=%0d scan=%0d look=%0d last=%0d"},
                     exp_r.kind, exp_r.cyl, exp_r.fcfs, exp_r.scan, exp_r.look,
                     exp_r.last, item_kind_o, served_cylinder_o, fcfs_travel_o,
                     scan_travel_o, look_travel_o, last_item_o);
        end
      end
    end
  end

  // defaults after reset; edge values, bit patterns and head hits
  task automatic test_directed();
    logic [dss_pkg::CylW-1:0] pat[NReq];
    pat = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd0, 16'd299, 16'd300, 16'd1,
            16'd150, 16'd150, 16'hFFFE, 16'd298, 16'h8000, 16'h7FFF, 16'd0, 16'd42,
            16'd42, 16'd1000, 16'd2, 16'h00FF, 16'hFF00, 16'd0, 16'd65000, 16'd77,
            16'd5, 16'd9999, 16'd123, 16'd299, 16'd31, 16'd0, 16'hFFFF, 16'd7};
    foreach (pat[i]) send_request(pat[i]);
    drain();
  endtask

  // extreme settings: head ends, both directions, max at 1, 0 and top
  task automatic test_config_sweep();
    set_config(16'd0, 1'b1, 16'hFFFF);
    random_batch(0);
    drain();
    set_config(16'hFFFF, 1'b1, 16'd1);
    random_batch(2);
    drain();
    set_config(16'hFFFF, 1'b0, 16'd0);
    random_batch(0);
    drain();
    set_config(16'd500, 1'b1, 16'd100);
    random_batch(1);
    drain();
  endtask

  // result side held off while requests keep coming
  task automatic test_backpressure();
    set_config(16'd30000, 1'b0, 16'd60000);
    hold_cycles = 400;
    random_batch(0);
    random_batch(1);
    drain();
  endtask

  // random settings, no idling for one batch
  task automatic test_random();
    for (int b = 0; b < 2; b++) begin
      set_config(dss_pkg::CylW'($urandom), 1'($urandom),
                 dss_pkg::CylW'($urandom_range(1, 65535)));
      idle_en = (b != 0);
      random_batch($urandom_range(0, 2));
      drain();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    $display("Covered %0d requests in %0d batches, %0d results checked, %0d mismatches.",
             n_sent, n_batches, n_results, n_errors);
    $display("Settings spanned both sweep directions and head/max extremes.");
    if (n_errors == 0 && service_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
sv/dss_pkg.sv
sv/dss_front.sv
sv/dss_back.sv
sv/disk_seek_scheduler.sv
test/tb_top.sv
